[rtl/mtbr_pkg.sv]
//==============================================================================
// MT19937 bounded random package
// Shared constants, controller command and status structures.
//==============================================================================
`default_nettype none

package mtbr_pkg;

    localparam int unsigned STATE_WORDS_DEF  = 624;
    localparam int unsigned TWIST_OFFSET_DEF = 397;
    localparam logic [31:0] SEED_RESET       = 32'd5489;
    localparam logic [31:0] INIT_MULT        = 32'd1812433253;
    localparam int unsigned INIT_SHIFT       = 30;
    localparam logic [31:0] MATRIX_A         = 32'h9908_B0DF;
    localparam logic [31:0] TEMPER_B         = 32'h9D2C_5680;
    localparam logic [31:0] TEMPER_C         = 32'hEFC6_0000;

    // Datapath operations issued by the controller.
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_FILL_INIT = 4'd1;  // write word 0 = seed
    localparam logic [3:0] OP_FILL_RD   = 4'd2;  // read previous word
    localparam logic [3:0] OP_FILL_MUL  = 4'd3;  // multiply
    localparam logic [3:0] OP_FILL_WR   = 4'd4;  // add index, write
    localparam logic [3:0] OP_TW_RD0    = 4'd5;  // read word i
    localparam logic [3:0] OP_TW_RD1    = 4'd6;  // read word i+1
    localparam logic [3:0] OP_TW_RD2    = 4'd7;  // read word i+m
    localparam logic [3:0] OP_TW_WR     = 4'd8;  // write twisted word
    localparam logic [3:0] OP_DRAW_RD   = 4'd9;  // read word at index
    localparam logic [3:0] OP_TEMPER    = 4'd10; // temper and mask
    localparam logic [3:0] OP_SETUP     = 4'd11; // range, lower bound, span
    localparam logic [3:0] OP_MOD_START = 4'd12; // start remainder
    localparam logic [3:0] OP_MOD_STEP  = 4'd13; // one restoring step
    localparam logic [3:0] OP_RESULT    = 4'd14; // load output register

    typedef struct packed {
        logic [3:0] op;
        logic       scale_mode;  // remainder step computes span % range
        logic       raw_result;  // full span: result is raw word
        logic       bad_result;  // upper below lower
    } mtbr_cmd_t;

    typedef struct packed {
        logic inverted;     // upper below lower
        logic full_span;    // range wraps to zero
        logic fill_last;    // fill counter at last word
        logic twist_last;   // twist counter at last word
        logic need_twist;   // word index at end of array
        logic mod_done;     // remainder finished
        logic accept_ok;    // masked draw below scale
    } mtbr_sts_t;

endpackage

`default_nettype wire

[rtl/mt19937_bounded_random_top.sv]
//==============================================================================
// MT19937 bounded random generator, top level
// Returns a uniform signed integer in an inclusive range per request.
//==============================================================================
// Usage:
//   The input channel (in_valid/in_stall) carries lower_bound and upper_bound;
//   the output channel (out_valid/out_stall) returns value, one beat per
//   request. Writing seed (seed_we/seed_wdata) refills the 624-word state.
// Reset and seeding: the state memory is filled by the initializer, word by
//   word (read, multiply, add index, write), while in_stall stays high.
// Sequence: setup and the span remainder, then draws with rejection, then the
//   result remainder; a draw that lands at the end of the array first twists
//   the whole array, word by word. The bit-serial remainder unit and the single
//   memory port set the pace. A full-span request skips both remainders and
//   inverted bounds go straight to the result.
// Stalls: a result waits in the output register while out_stall is high;
//   no new request is taken until it has been delivered.
//==============================================================================
`default_nettype none

module mt19937_bounded_random_top
    import mtbr_pkg::*;
#(
    parameter int unsigned STATE_WORDS  = STATE_WORDS_DEF,
    parameter int unsigned TWIST_OFFSET = TWIST_OFFSET_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        seed_we,
    input  wire logic [31:0] seed_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] lower_bound,
    input  wire logic [31:0] upper_bound,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      value
);

    mtbr_cmd_t   cmd;
    mtbr_sts_t   sts;
    logic [31:0] seed_reg;

    // Seed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (seed_we)
        begin
            seed_reg <= seed_wdata;
        end
    end

    mtbr_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (seed_we),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    mtbr_datapath #(
        .STATE_WORDS  (STATE_WORDS),
        .TWIST_OFFSET (TWIST_OFFSET)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .seed        (seed_reg),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .result      (value)
    );

endmodule

`default_nettype wire

[rtl/mtbr_datapath.sv]
//==============================================================================
// MT19937 bounded random datapath
// State memory, initializer, twist, tempering, range setup and a bit-serial
// restoring remainder unit.
//==============================================================================
`default_nettype none

module mtbr_datapath
    import mtbr_pkg::*;
#(
    parameter int unsigned STATE_WORDS  = STATE_WORDS_DEF,
    parameter int unsigned TWIST_OFFSET = TWIST_OFFSET_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire mtbr_cmd_t   cmd,
    output mtbr_sts_t        sts,
    input  wire logic [31:0] seed,
    input  wire logic [31:0] lower_bound,
    input  wire logic [31:0] upper_bound,
    output logic [31:0]      result
);

    localparam int unsigned AW = $clog2(STATE_WORDS);
    localparam int unsigned IW = $clog2(STATE_WORDS + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(STATE_WORDS - 1);

    // State memory, one port, registered read data.
    logic [31:0] mem [STATE_WORDS];
    logic [31:0] rd_reg;
    logic        we;
    logic [AW-1:0] addr;
    logic [31:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rd_reg <= mem[addr];
    end

    // Counters: fill/twist position and the draw index.
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [AW-1:0] cnt_p1, cnt_pm;

    always_comb
    begin
        cnt_p1 = (cnt_reg == LAST_ADDR) ? '0 : cnt_reg + AW'(1);
        if ({1'b0, cnt_reg} + (AW+1)'(TWIST_OFFSET) >= (AW+1)'(STATE_WORDS))
        begin
            cnt_pm = AW'({1'b0, cnt_reg} + (AW+1)'(TWIST_OFFSET)
                         - (AW+1)'(STATE_WORDS));
        end
        else
        begin
            cnt_pm = AW'({1'b0, cnt_reg} + (AW+1)'(TWIST_OFFSET));
        end
    end

    // Working registers.
    logic [31:0] prod_reg, prod_next;
    logic [31:0] a_reg, a_next;     // twist: word i upper bit source
    logic [31:0] b_reg, b_next;     // twist: word i+1
    logic [31:0] word_reg, word_next;
    logic [31:0] range_reg, range_next;
    logic [31:0] lo_reg, lo_next;   // lower bound of the accepted beat
    logic [32:0] span_reg, span_next;
    logic [32:0] scale_reg, scale_next;
    logic [31:0] rem_reg, rem_next;
    logic [32:0] quo_reg, quo_next;  // dividend bits shifted out
    logic [5:0]  step_reg, step_next;
    logic [31:0] res_reg, res_next;

    logic [31:0] y, tw, t;
    logic [32:0] trial;
    logic [5:0]  nbits;

    // Tempering of the word just read.
    always_comb
    begin
        t = rd_reg;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
    end

    // Twist of one word from words i, i+1 and i+m.
    always_comb
    begin
        y  = {a_reg[31], b_reg[30:0]};
        tw = rd_reg ^ (y >> 1) ^ (y[0] ? MATRIX_A : 32'd0);
    end

    // Bit count for the range, a priority search over 32 bits.
    always_comb
    begin
        logic [31:0] rm1;
        rm1   = (upper_bound - lower_bound);
        nbits = 6'd0;
        for (int k = 0; k < 32; k++)
        begin
            if (rm1[k])
            begin
                nbits = 6'(k + 1);
            end
        end
    end

    always_comb
    begin
        trial = {rem_reg, quo_reg[32]} - {1'b0, range_reg};
    end

    // Datapath operations.
    always_comb
    begin
        we         = 1'b0;
        addr       = cnt_reg;
        wdata      = prod_reg + 32'(cnt_reg);
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        prod_next  = prod_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        word_next  = word_reg;
        range_next = range_reg;
        lo_next    = lo_reg;
        span_next  = span_reg;
        scale_next = scale_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        step_next  = step_reg;
        res_next   = res_reg;
        case (cmd.op)
            OP_FILL_INIT:
            begin
                we       = 1'b1;
                addr     = '0;
                wdata    = seed;
                cnt_next = AW'(1);
                idx_next = IW'(STATE_WORDS);
            end
            OP_FILL_RD:
            begin
                addr = cnt_reg - AW'(1);
            end
            OP_FILL_MUL:
            begin
                prod_next = INIT_MULT * (rd_reg ^ (rd_reg >> INIT_SHIFT));
            end
            OP_FILL_WR:
            begin
                we       = 1'b1;
                cnt_next = cnt_p1;
            end
            OP_TW_RD0:
            begin
                addr = cnt_reg;
            end
            OP_TW_RD1:
            begin
                addr   = cnt_p1;
                a_next = rd_reg;
            end
            OP_TW_RD2:
            begin
                addr   = cnt_pm;
                b_next = rd_reg;
            end
            OP_TW_WR:
            begin
                we       = 1'b1;
                wdata    = tw;
                cnt_next = cnt_p1;
                if (cnt_reg == LAST_ADDR)
                begin
                    idx_next = '0;
                end
            end
            OP_DRAW_RD:
            begin
                addr     = AW'(idx_reg);
                idx_next = idx_reg + IW'(1);
            end
            OP_TEMPER:
            begin
                word_next = t & span_reg[31:0] - 32'd1 | (span_reg[32] ? t : 32'd0);
                if (cmd.raw_result)
                begin
                    word_next = t;
                end
            end
            OP_SETUP:
            begin
                range_next = upper_bound - lower_bound + 32'd1;
                lo_next    = lower_bound;
                span_next  = 33'd1 << nbits;
            end
            OP_MOD_START:
            begin
                rem_next  = '0;
                quo_next  = cmd.scale_mode ? span_reg : {1'b0, word_reg};
                step_next = cmd.scale_mode ? 6'd33 : 6'd32;
                if (!cmd.scale_mode)
                begin
                    quo_next = {word_reg, 1'b0};
                end
            end
            OP_MOD_STEP:
            begin
                if (!trial[32])
                begin
                    rem_next = trial[31:0];
                end
                else
                begin
                    rem_next = {rem_reg[30:0], quo_reg[32]};
                end
                quo_next  = {quo_reg[31:0], 1'b0};
                step_next = step_reg - 6'd1;
                if (step_reg == 6'd1 && cmd.scale_mode)
                begin
                    scale_next = span_reg - 33'(rem_next);
                end
            end
            OP_RESULT:
            begin
                if (cmd.bad_result)
                begin
                    res_next = lo_reg;
                end
                else if (cmd.raw_result)
                begin
                    res_next = word_reg;
                end
                else
                begin
                    res_next = lo_reg + rem_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            idx_reg  <= IW'(STATE_WORDS);
            step_reg <= '0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        word_reg  <= word_next;
        range_reg <= range_next;
        lo_reg    <= lo_next;
        span_reg  <= span_next;
        scale_reg <= scale_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        res_reg   <= res_next;
    end

    // Status toward the controller.
    always_comb
    begin
        sts.inverted   = $signed(upper_bound) < $signed(lower_bound);
        sts.full_span  = (upper_bound - lower_bound) == 32'hFFFF_FFFF;
        sts.fill_last  = (cnt_reg == LAST_ADDR);
        sts.twist_last = (cnt_reg == LAST_ADDR);
        sts.need_twist = (idx_reg >= IW'(STATE_WORDS));
        sts.mod_done   = (step_reg == 6'd0);
        sts.accept_ok  = {1'b0, word_reg} < scale_reg;
    end

    assign result = res_reg;

endmodule

`default_nettype wire

[rtl/mtbr_ctrl.sv]
//==============================================================================
// MT19937 bounded random controller
// Sequences seeding, twisting, drawing, rejection and the remainder.
//==============================================================================
`default_nettype none

module mtbr_ctrl
    import mtbr_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_we,
    input  wire logic      in_valid,
    output logic           in_stall,
    output logic           out_valid,
    input  wire logic      out_stall,
    input  wire mtbr_sts_t sts,
    output mtbr_cmd_t      cmd
);

    localparam logic [4:0] S_FILL0   = 5'd0;
    localparam logic [4:0] S_FILL_RD = 5'd1;
    localparam logic [4:0] S_FILL_WT = 5'd2;
    localparam logic [4:0] S_FILL_MU = 5'd3;
    localparam logic [4:0] S_FILL_WR = 5'd4;
    localparam logic [4:0] S_IDLE    = 5'd5;
    localparam logic [4:0] S_SETUP   = 5'd6;
    localparam logic [4:0] S_SC_ST   = 5'd7;
    localparam logic [4:0] S_SC_STEP = 5'd8;
    localparam logic [4:0] S_DRAW    = 5'd9;
    localparam logic [4:0] S_TW0     = 5'd10;
    localparam logic [4:0] S_TW1     = 5'd11;
    localparam logic [4:0] S_TW2     = 5'd12;
    localparam logic [4:0] S_TW3     = 5'd13;
    localparam logic [4:0] S_RD      = 5'd14;
    localparam logic [4:0] S_TEMP    = 5'd15;
    localparam logic [4:0] S_CHECK   = 5'd16;
    localparam logic [4:0] S_MOD_ST  = 5'd17;
    localparam logic [4:0] S_MOD     = 5'd18;
    localparam logic [4:0] S_RES     = 5'd19;
    localparam logic [4:0] S_OUT     = 5'd20;

    logic [4:0] state_reg, state_next;
    logic       full_reg, full_next;
    logic       bad_reg, bad_next;
    logic       ov_reg, ov_next;

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        full_next      = full_reg;
        bad_next       = bad_reg;
        ov_next        = ov_reg;
        cmd.op         = OP_NONE;
        cmd.scale_mode = 1'b0;
        cmd.raw_result = full_reg;
        cmd.bad_result = bad_reg;
        in_stall       = 1'b1;
        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            S_FILL0:
            begin
                cmd.op     = OP_FILL_INIT;
                state_next = S_FILL_RD;
            end
            S_FILL_RD:
            begin
                cmd.op     = OP_FILL_RD;
                state_next = S_FILL_WT;
            end
            S_FILL_WT:
            begin
                // Keep the previous word on the read port for the multiply.
                cmd.op     = OP_FILL_RD;
                state_next = S_FILL_MU;
            end
            S_FILL_MU:
            begin
                cmd.op     = OP_FILL_MUL;
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.op     = OP_FILL_WR;
                state_next = sts.fill_last ? S_IDLE : S_FILL_RD;
            end
            S_IDLE:
            begin
                in_stall = ov_reg;
                if (in_valid && !ov_reg)
                begin
                    full_next = sts.full_span;
                    bad_next  = sts.inverted;
                    cmd.op    = OP_SETUP;
                    if (sts.inverted)
                    begin
                        state_next = S_RES;
                    end
                    else if (sts.full_span)
                    begin
                        state_next = S_DRAW;
                    end
                    else
                    begin
                        state_next = S_SC_ST;
                    end
                end
            end
            S_SC_ST:
            begin
                cmd.op         = OP_MOD_START;
                cmd.scale_mode = 1'b1;
                state_next     = S_SC_STEP;
            end
            S_SC_STEP:
            begin
                cmd.op         = OP_MOD_STEP;
                cmd.scale_mode = 1'b1;
                if (sts.mod_done)
                begin
                    cmd.op     = OP_NONE;
                    state_next = S_DRAW;
                end
            end
            S_DRAW:
            begin
                state_next = sts.need_twist ? S_TW0 : S_RD;
            end
            S_TW0:
            begin
                cmd.op     = OP_TW_RD0;
                state_next = S_TW1;
            end
            S_TW1:
            begin
                cmd.op     = OP_TW_RD1;
                state_next = S_TW2;
            end
            S_TW2:
            begin
                cmd.op     = OP_TW_RD2;
                state_next = S_TW3;
            end
            S_TW3:
            begin
                cmd.op     = OP_TW_WR;
                state_next = sts.twist_last ? S_RD : S_TW0;
            end
            S_RD:
            begin
                cmd.op     = OP_DRAW_RD;
                state_next = S_TEMP;
            end
            S_TEMP:
            begin
                cmd.op     = OP_TEMPER;
                state_next = full_reg ? S_RES : S_CHECK;
            end
            S_CHECK:
            begin
                state_next = sts.accept_ok ? S_MOD_ST : S_DRAW;
            end
            S_MOD_ST:
            begin
                cmd.op     = OP_MOD_START;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                cmd.op = OP_MOD_STEP;
                if (sts.mod_done)
                begin
                    cmd.op     = OP_NONE;
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                cmd.op     = OP_RESULT;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_FILL0;
            end
        endcase
        if (cfg_we)
        begin
            state_next = S_FILL0;
        end
    end

    assign out_valid = ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL0;
            full_reg  <= 1'b0;
            bad_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg  <= full_next;
            bad_reg   <= bad_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
//------------------------------------------------------------------------------
// Bounded MT19937 generator testbench
// Drives signed range requests through the valid/stall input channel and
// checks every returned value against a local twister model.
// The seed is rewritten between phases. Both channels idle at random.
//------------------------------------------------------------------------------
module tb_top
    import mtbr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_WORDS     = 624;
    localparam int SHIFT_OFFSET  = 397;
    localparam int RANDOM_ITEMS  = 1330;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct {
        logic [31:0] lo;
        logic [31:0] hi;
        bit          fixed;
        logic [31:0] want;
    } range_req_t;

    logic        clk;
    logic        rst_n;
    logic        seed_we;
    logic [31:0] seed_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] lower_bound;
    logic [31:0] upper_bound;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] value;

    // Local copy of the generator state.
    logic [31:0] gen_words [NUM_WORDS];
    int          gen_index;
    logic [31:0] expected_values [$];
    int          error_count;
    int          cycle_count;
    bit          calm;

    mt19937_bounded_random_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .seed_we     (seed_we),
        .seed_wdata  (seed_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .lower_bound (lower_bound),
        .upper_bound (upper_bound),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Refill the state from a seed word with the standard initializer.
    function automatic void seed_state(logic [31:0] s);
        logic [31:0] p;
        gen_words[0] = s;
        for (int i = 1; i < NUM_WORDS; i++)
        begin
            p = gen_words[i - 1];
            gen_words[i] = INIT_MULT * (p ^ (p >> INIT_SHIFT)) + 32'(i);
        end
        gen_index = NUM_WORDS;
    endfunction

    // Regenerate the whole array in place.
    function automatic void twist_state();
        logic [31:0] y;
        logic [31:0] w;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            y = (gen_words[i] & 32'h8000_0000) |
                (gen_words[(i + 1) % NUM_WORDS] & 32'h7FFF_FFFF);
            w = gen_words[(i + SHIFT_OFFSET) % NUM_WORDS] ^ (y >> 1);
            if (y[0])
                w = w ^ MATRIX_A;
            gen_words[i] = w;
        end
        gen_index = 0;
    endfunction

    // Next tempered word.
    function automatic logic [31:0] tempered_word();
        logic [31:0] y;
        if (gen_index >= NUM_WORDS)
            twist_state();
        y = gen_words[gen_index];
        gen_index++;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    // Expected value for one range request; advances the state unless the bounds are inverted.
    function automatic logic [31:0] bounded_value(logic [31:0] lo, logic [31:0] hi);
        logic [31:0]     rng;
        logic [31:0]     pick;
        longint unsigned span;
        longint unsigned limit;
        int              bits;
        if ((hi ^ 32'h8000_0000) < (lo ^ 32'h8000_0000))
            return lo;
        rng = hi - lo + 32'd1;
        if (rng == 32'd0)
            return tempered_word();
        bits = 0;
        while (bits < 32 && (64'd1 << bits) < longint'(rng))
            bits++;
        span  = 64'd1 << bits;
        limit = span - (span % rng);
        do
            pick = 32'(longint'(tempered_word()) & (span - 1));
        while (longint'(pick) >= limit);
        return lo + pick % rng;
    endfunction

    // Present one beat and hold it until accepted.
    task automatic send_range(range_req_t r);
        int          gap;
        logic [31:0] want;
        gap = (!calm && $urandom_range(99) < 37) ? $urandom_range(1, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        lower_bound <= r.lo;
        upper_bound <= r.hi;
        do
            @(posedge clk);
        while (in_stall);
        want = bounded_value(r.lo, r.hi);
        expected_values.push_back(r.fixed ? r.want : want);
    endtask

    // Write the seed once every result has come back.
    task automatic load_seed(logic [31:0] s);
        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        seed_we    <= 1'b1;
        seed_wdata <= s;
        @(posedge clk);
        seed_we    <= 1'b0;
        seed_state(s);
    endtask

    task automatic random_phase(int count);
        range_req_t r;
        int         kind;
        for (int n = 0; n < count; n++)
        begin
            calm   = (n >= count / 3) && (n < count / 3 + 60);
            kind   = $urandom_range(99);
            r.lo   = $urandom;
            r.fixed = 1'b0;
            r.want = '0;
            if (kind < 40)
                r.hi = r.lo + $urandom_range(0, 40);
            else if (kind < 55)
                r.hi = r.lo + (32'd1 << $urandom_range(0, 31)) - 32'd1;
            else if (kind < 75)
                r.hi = r.lo + $urandom_range(0, 32'h7FFF_FFFF);
            else if (kind < 88)
                r.hi = $urandom;
            else if (kind < 94)
                r.hi = r.lo - $urandom_range(1, 1000);
            else
            begin
                r.lo = 32'h8000_0000;
                r.hi = 32'h7FFF_FFFF;
            end
            send_range(r);
        end
        calm = 1'b0;
        in_valid <= 1'b0;
    endtask

    // Directed rows; fixed answers only where obvious.
    range_req_t directed_rows [20] = '{
        '{32'd5,          32'hFFFF_FFFB, 1'b1, 32'd5},
        '{32'h7FFF_FFFF,  32'h8000_0000, 1'b1, 32'h7FFF_FFFF},
        '{32'h8000_0000,  32'h8000_0000, 1'b1, 32'h8000_0000},
        '{32'h7FFF_FFFF,  32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF},
        '{32'd0,          32'd0,         1'b1, 32'd0},
        '{32'hFFFF_FFFF,  32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
        '{32'h8000_0000,  32'h7FFF_FFFF, 1'b0, 32'd0},
        '{32'h8000_0000,  32'h7FFF_FFFF, 1'b0, 32'd0},
        '{32'd0,          32'd1,         1'b0, 32'd0},
        '{32'd10,         32'd12,        1'b0, 32'd0},
        '{32'hFFFF_FFF6,  32'd10,        1'b0, 32'd0},
        '{32'h8000_0000,  32'd0,         1'b0, 32'd0},
        '{32'h8000_0000,  32'h7FFF_FFFE, 1'b0, 32'd0},
        '{32'hFFFF_FFFF,  32'h7FFF_FFFF, 1'b0, 32'd0},
        '{32'd0,          32'h7FFF_FFFF, 1'b0, 32'd0},
        '{32'd100,        32'd99,        1'b1, 32'd100},
        '{32'd0,          32'd6,         1'b0, 32'd0},
        '{32'h8000_0000,  32'h8000_0001, 1'b0, 32'd0},
        '{32'h7FFF_FFF0,  32'h7FFF_FFFF, 1'b0, 32'd0},
        '{32'h1234_5678,  32'h1234_5678, 1'b1, 32'h1234_5678}
    };

    // Result side: random stall and comparison against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_values.size() == 0)
                begin
                    $display("%0t: unexpected value beat, expected none, actual %h",
                             $realtime, value);
                    error_count++;
                end
                else
                begin
                    if (value !== expected_values[0])
                    begin
                        $display("%0t: value mismatch, expected %h, actual %h",
                                 $realtime, expected_values[0], value);
                        error_count++;
                    end
                    void'(expected_values.pop_front());
                end
            end
            out_stall <= (!calm && $urandom_range(99) < 37);
        end
    end

    // Runaway guard.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Main sequence.
    initial
    begin
        seed_we     = 1'b0;
        seed_wdata  = '0;
        in_valid    = 1'b0;
        lower_bound = '0;
        upper_bound = '0;
        rst_n       = 1'b0;
        error_count = 0;
        cycle_count = 0;
        calm        = 1'b0;
        seed_state(SEED_RESET);
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_range(directed_rows[i]);
        in_valid <= 1'b0;

        load_seed(32'd0);
        random_phase(RANDOM_ITEMS / 4);
        load_seed(32'hFFFF_FFFF);
        random_phase(RANDOM_ITEMS / 4);
        load_seed($urandom);
        random_phase(RANDOM_ITEMS / 2);

        while (expected_values.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (error_count == 0 && expected_values.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

[filelist.f]
rtl/mtbr_pkg.sv
rtl/mtbr_datapath.sv
rtl/mtbr_ctrl.sv
rtl/mt19937_bounded_random_top.sv
test/tb_top.sv
